FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL core of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, switched off while rst is high.
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also active during reset.
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bdq_pkg.sv
// Package with the operation codes, status codes and default sizes of the deque block.
`default_nettype none

package bdq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_TOP    = 3'd0;
  localparam logic [2:0] OP_PUSH_BOTTOM = 3'd1;
  localparam logic [2:0] OP_POP_TOP     = 3'd2;
  localparam logic [2:0] OP_POP_BOTTOM  = 3'd3;
  localparam logic [2:0] OP_REVERSE     = 3'd4;
  localparam logic [2:0] OP_SPLIT       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/bounded_deque_with_split_core.sv
// Top level of the bounded deque with reverse and split, held in a ring store.
// Push, reverse, unused codes and a pop on an empty deque answer in the cycle after the transfer.
// A pop of a stored word answers from the S_POP state, after the registered read of the store.
// Split runs two compare passes and one copy pass, one element per cycle; a new transfer
// waits for the last result.
// Synchronous reset empties the queue at once; the stores are not cleared.
`default_nettype none

`include "assert_macros.svh"

module bounded_deque_with_split_core
  import bdq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [2:0]                         op,
  input  wire logic signed [WORD_W-1:0]           value,
  input  wire logic signed [WORD_W-1:0]           threshold,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [WORD_W-1:0]                popped_value,
  output logic [1:0]                              status,
  output logic [$clog2(CAPACITY+1)-1:0]           element_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0] CAP_W = (IW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [IW-1:0] CAP_M1 = IW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_POP     = 5'b00010,
    S_PASS_HI = 5'b00100,
    S_PASS_LO = 5'b01000,
    S_COPY    = 5'b10000
  } state_t;

  state_t state;

  logic signed [WORD_W-1:0] store [CAPACITY];
  logic signed [WORD_W-1:0] scratch [CAPACITY];
  logic signed [WORD_W-1:0] store_rd;
  logic signed [WORD_W-1:0] scratch_rd;
  logic signed [WORD_W-1:0] thr;

  logic [IW-1:0] front;
  logic [CW-1:0] count;
  logic          rev;
  logic [CW-1:0] idx;
  logic [CW-1:0] fill;
  logic [IW-1:0] idx_d;
  logic          pv;

  logic          accept;
  logic          is_push;
  logic          is_pop;
  logic          push_front;
  logic          pop_front;
  logic          full;
  logic          empty;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] slot_back_push;
  logic [IW-1:0] slot_back_pop;
  logic [CW-1:0] pos_off;
  logic [IW-1:0] rd_addr;
  logic          store_we;
  logic [IW-1:0] store_wa;
  logic signed [WORD_W-1:0] store_wd;
  logic          scratch_we;
  logic          issue;
  logic          lt;
  logic          pass_state;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[IW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  assign is_push = (op == OP_PUSH_TOP) || (op == OP_PUSH_BOTTOM);
  assign is_pop = (op == OP_POP_TOP) || (op == OP_POP_BOTTOM);
  assign push_front = (op == OP_PUSH_TOP) != rev;
  assign pop_front = (op == OP_POP_TOP) != rev;
  assign full = (count >= CAP_C);
  assign empty = (count == '0);

  assign front_dec = wrap_add(front, CAP_M1);
  assign front_inc = wrap_add(front, IW'(1));
  assign slot_back_push = wrap_add(front, count[IW-1:0]);
  assign slot_back_pop = wrap_add(front, IW'(count - CW'(1)));

  assign pass_state = (state == S_PASS_HI) || (state == S_PASS_LO);
  assign pos_off = rev ? (count - CW'(1) - idx) : idx;
  assign issue = (idx < count);
  assign lt = store_rd < thr;

  always_comb begin
    if (pass_state) begin
      rd_addr = wrap_add(front, pos_off[IW-1:0]);
    end else if (pop_front) begin
      rd_addr = front;
    end else begin
      rd_addr = slot_back_pop;
    end
  end

  always_comb begin
    store_we = 1'b0;
    store_wa = idx_d;
    store_wd = scratch_rd;
    if (state == S_COPY) begin
      store_we = pv;
    end else if (state == S_IDLE && accept && is_push && !full) begin
      store_we = 1'b1;
      store_wa = push_front ? front_dec : slot_back_push;
      store_wd = value;
    end
  end

  assign scratch_we = pv && (((state == S_PASS_HI) && !lt) || ((state == S_PASS_LO) && lt));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_wa] <= store_wd;
    end
    store_rd <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (scratch_we) begin
      scratch[fill[IW-1:0]] <= store_rd;
    end
    scratch_rd <= scratch[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      rev <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
      fill <= '0;
      pv <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            popped_value <= '0;
            thr <= threshold;
            idx <= '0;
            fill <= '0;
            pv <= 1'b0;
            if (is_push) begin
              out_valid <= 1'b1;
              if (full) begin
                status <= ST_FULL;
                element_count <= count;
              end else begin
                status <= ST_OK;
                count <= count + CW'(1);
                element_count <= count + CW'(1);
                if (push_front) begin
                  front <= front_dec;
                end
              end
            end else if (is_pop) begin
              if (empty) begin
                out_valid <= 1'b1;
                status <= ST_EMPTY;
                element_count <= count;
              end else begin
                state <= S_POP;
                count <= count - CW'(1);
                if (pop_front) begin
                  front <= front_inc;
                end
              end
            end else if (op == OP_REVERSE) begin
              out_valid <= 1'b1;
              status <= ST_OK;
              element_count <= count;
              rev <= !rev;
            end else if (op == OP_SPLIT) begin
              state <= S_PASS_HI;
            end else begin
              out_valid <= 1'b1;
              status <= ST_OK;
              element_count <= count;
            end
          end
        end
        S_POP: begin
          out_valid <= 1'b1;
          popped_value <= store_rd;
          status <= ST_OK;
          element_count <= count;
          state <= S_IDLE;
        end
        S_PASS_HI, S_PASS_LO, S_COPY: begin
          pv <= issue;
          idx_d <= idx[IW-1:0];
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (scratch_we) begin
            fill <= fill + CW'(1);
          end
          if (!issue && !pv) begin
            idx <= '0;
            if (state == S_PASS_HI) begin
              state <= S_PASS_LO;
            end else if (state == S_PASS_LO) begin
              state <= S_COPY;
            end else begin
              state <= S_IDLE;
              front <= '0;
              rev <= 1'b0;
              out_valid <= 1'b1;
              popped_value <= '0;
              status <= ST_OK;
              element_count <= count;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BDQ_ASSERT(a_count_bound, count <= CAP_C, "element count exceeds capacity")
  `BDQ_ASSERT(a_full_status, accept && full && ((op == OP_PUSH_TOP) || (op == OP_PUSH_BOTTOM)) |=> out_valid && (status == ST_FULL), "push on full queue did not report full")
  `BDQ_ASSERT(a_empty_zero, out_valid && (status == ST_EMPTY) |-> (popped_value == '0), "empty pop returned a nonzero word")
  `BDQ_ASSERT(a_fill_bound, (state == S_COPY) |-> (fill == count), "split passes lost or duplicated an element")

endmodule

`default_nettype wire

FILE: verif/bounded_deque_with_split_core_tb.sv
// Self-checking testbench for the bounded deque core with reverse and split operations.
`timescale 1ns / 100ps

module bounded_deque_with_split_core_tb;
  import bdq_pkg::*;

  localparam int DEPTH_MAX = DEFAULT_CAPACITY;
  localparam int CNT_W = $clog2(DEPTH_MAX + 1);
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 250;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [1:0] st;
    logic [CNT_W-1:0] cnt;
  } deque_outcome_t;

  class deque_scoreboard_t;
    logic signed [WORD_W-1:0] words[$];
    deque_outcome_t awaited[$];
    int errors;
    int ops_seen;
    int pops_ok;
    int empty_hits;
    int full_hits;
    int splits;

    function int depth();
      return words.size();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic signed [WORD_W-1:0] any_word();
      if (words.size() == 0) return '0;
      return words[$urandom_range(0, words.size() - 1)];
    endfunction

    // The queue is held top first, so index 0 is the top of the deque.
    function void apply_op(logic [2:0] code, logic signed [WORD_W-1:0] word,
                           logic signed [WORD_W-1:0] cut);
      deque_outcome_t o;
      logic signed [WORD_W-1:0] upper[$];
      logic signed [WORD_W-1:0] lower[$];
      logic signed [WORD_W-1:0] flipped[$];
      o.popped = '0;
      o.st = ST_OK;
      ops_seen++;
      case (code)
        OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
          if (words.size() >= DEPTH_MAX) begin
            o.st = ST_FULL;
            full_hits++;
          end else if (code == OP_PUSH_TOP) begin
            words.push_front(word);
          end else begin
            words.push_back(word);
          end
        end
        OP_POP_TOP, OP_POP_BOTTOM: begin
          if (words.size() == 0) begin
            o.st = ST_EMPTY;
            empty_hits++;
          end else begin
            o.popped = (code == OP_POP_TOP) ? words.pop_front() : words.pop_back();
            pops_ok++;
          end
        end
        OP_REVERSE: begin
          foreach (words[i]) flipped.push_front(words[i]);
          words = flipped;
        end
        OP_SPLIT: begin
          foreach (words[i]) begin
            if (words[i] < cut) lower.push_back(words[i]);
            else upper.push_back(words[i]);
          end
          words = {upper, lower};
          splits++;
        end
        default: begin
        end
      endcase
      o.cnt = CNT_W'(words.size());
      awaited.push_back(o);
    endfunction

    task log_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_result(logic signed [WORD_W-1:0] popped, logic [1:0] st,
                        logic [CNT_W-1:0] cnt);
      deque_outcome_t o;
      if (awaited.size() == 0) begin
        log_mismatch($sformatf("result with no pending operation (count %0d)", cnt));
        return;
      end
      o = awaited.pop_front();
      if (popped !== o.popped)
        log_mismatch($sformatf("popped_value %0d, expected %0d", popped, o.popped));
      if (st !== o.st)
        log_mismatch($sformatf("status %0d, expected %0d", st, o.st));
      if (cnt !== o.cnt)
        log_mismatch($sformatf("element_count %0d, expected %0d", cnt, o.cnt));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [2:0] op = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic signed [WORD_W-1:0] threshold = '0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire signed [WORD_W-1:0] popped_value;
  wire [1:0] status;
  wire [CNT_W-1:0] element_count;

  deque_scoreboard_t board;
  bit quiet_in;
  bit quiet_out;
  int stall_left;
  int idle_cycles;
  int random_ops;

  bounded_deque_with_split_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .value(value),
    .threshold(threshold),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .popped_value(popped_value),
    .status(status),
    .element_count(element_count)
  );

  always #5 clk = ~clk;

  task automatic send_op(logic [2:0] code, logic signed [WORD_W-1:0] word,
                         logic signed [WORD_W-1:0] cut);
    int gap;
    in_valid <= 1'b1;
    op <= code;
    value <= word;
    threshold <= cut;
    do @(posedge clk); while (in_stall);
    board.apply_op(code, word, cut);
    gap = quiet_in ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      4, 5: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] draw_op(traffic_mode_t mode);
    int r;
    int push_end;
    int pop_end;
    int rev_end;
    r = $urandom_range(0, 99);
    if (r < 2) return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    case (mode)
      MODE_FILL: begin push_end = 70; pop_end = 85; rev_end = 93; end
      MODE_DRAIN: begin push_end = 20; pop_end = 80; rev_end = 90; end
      default: begin push_end = 40; pop_end = 75; rev_end = 87; end
    endcase
    if (r < push_end) return $urandom_range(0, 1) ? OP_PUSH_TOP : OP_PUSH_BOTTOM;
    if (r < pop_end) return $urandom_range(0, 1) ? OP_POP_TOP : OP_POP_BOTTOM;
    if (r < rev_end) return OP_REVERSE;
    return OP_SPLIT;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.compare_result(popped_value, status, element_count);
        if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
        stall_left = quiet_out ? 0 : $urandom_range(0, 14);
        out_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Transfers stalled for %0d cycles.", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    traffic_mode_t mode;
    logic [2:0] code;
    logic signed [WORD_W-1:0] cut;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Operations on an empty deque and the spare codes, then pushes, pops, reverses and splits with the word extremes.
    send_op(OP_POP_TOP, 32'sh0, 32'sh0);
    send_op(OP_POP_BOTTOM, -32'sd1, -32'sd1);
    send_op(OP_SPLIT, 32'sh0, 32'sh0);
    send_op(OP_REVERSE, 32'sh0, 32'sh0);
    send_op(OP_SPARE_A, -32'sd1, -32'sd1);
    send_op(OP_SPARE_B, 32'sh12345678, 32'sh0);
    send_op(OP_PUSH_TOP, 32'sh7fffffff, 32'sh0);
    send_op(OP_SPLIT, 32'sh0, 32'sh80000000);
    send_op(OP_PUSH_BOTTOM, 32'sh80000000, 32'sh0);
    send_op(OP_PUSH_TOP, -32'sd1, 32'sh0);
    send_op(OP_PUSH_BOTTOM, 32'sh0, 32'sh0);
    send_op(OP_PUSH_TOP, 32'sd5, 32'sh0);
    send_op(OP_REVERSE, 32'sh0, 32'sh0);
    send_op(OP_POP_TOP, 32'sh0, 32'sh0);
    send_op(OP_PUSH_BOTTOM, 32'sd5, 32'sh0);
    send_op(OP_SPLIT, 32'sh0, 32'sh0);
    send_op(OP_SPLIT, 32'sh0, 32'sh7fffffff);
    send_op(OP_SPLIT, 32'sh0, 32'sh80000000);
    send_op(OP_REVERSE, 32'sh0, 32'sh0);
    send_op(OP_SPLIT, 32'sh0, 32'sd5);
    send_op(OP_POP_BOTTOM, 32'sh0, 32'sh0);
    send_op(OP_POP_TOP, 32'sh0, 32'sh0);
    send_op(OP_REVERSE, 32'sh0, 32'sh0);
    send_op(OP_POP_BOTTOM, 32'sh0, 32'sh0);

    mode = MODE_FILL;
    random_ops = 0;
    while (random_ops < RANDOM_ITEMS) begin
      if (random_ops % 48 == 0) begin
        if (board.depth() > DEPTH_MAX - 8) mode = MODE_DRAIN;
        else if (board.depth() < 8) mode = MODE_FILL;
        else mode = traffic_mode_t'($urandom_range(0, 2));
        if ($urandom_range(0, 4) == 0) quiet_in = !quiet_in;
      end
      code = draw_op(mode);
      cut = ($urandom_range(0, 9) < 3) ? board.any_word() : draw_word();
      send_op(code, draw_word(), cut);
      if (code != OP_SPARE_A && code != OP_SPARE_B) random_ops++;
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d pops, %0d pops on empty, %0d pushes on full.",
             board.ops_seen, board.pops_ok, board.empty_hits, board.full_hits);
    $display("Splits: %0d, mismatches: %0d.", board.splits, board.errors);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
